/* design/lkst_pkg.sv */
`default_nettype none

package lkst_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int KEY_W       = 32;
  localparam int MAX_W       = 5;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [MAX_W-1:0] MAX_ENTRIES_RESET = 5'd16;

  // register index, taken from paddr[CFG_ADDR_W-1:2]
  localparam logic REG_MAX_ENTRIES = 1'b0;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic capture;  // latch request and compare results
    logic commit;   // apply update, load result register
  } cmd_t;

endpackage

`default_nettype wire

/* design/lkst_ctrl.sv */
`default_nettype none

module lkst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output lkst_pkg::cmd_t     cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign cmd.capture = (state_r == ST_IDLE) && in_valid;
  assign cmd.commit  = (state_r == ST_UPD) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/lkst_dp.sv */
`default_nettype none

module lkst_dp #(
  parameter int ENTRIES = lkst_pkg::ENTRIES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire lkst_pkg::cmd_t                      cmd,
  input  wire logic                                in_req_type,
  input  wire logic signed [lkst_pkg::KEY_W-1:0]   in_key,
  input  wire logic        [lkst_pkg::MAX_W-1:0]   max_entries,
  output logic                                     out_hit,
  output logic                                     out_evicted,
  output logic signed      [lkst_pkg::KEY_W-1:0]   out_evicted_key
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > lkst_pkg::MAX_W) ? CNT_W : lkst_pkg::MAX_W;
  localparam int KEY_W  = lkst_pkg::KEY_W;

  // entry storage: key/rank are only read where the valid bit is set
  logic [KEY_W-1:0]  key_store_r [ENTRIES];
  logic [KEY_W-1:0]  key_store_nxt [ENTRIES];
  logic [RANK_W-1:0] rank_r [ENTRIES];
  logic [RANK_W-1:0] rank_nxt [ENTRIES];
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  // request and compare results captured at the input beat
  logic [ENTRIES-1:0] hit_vec_r, evict_vec_r, free_vec_r;
  logic               need_evict_r;
  logic               req_type_r;
  logic [KEY_W-1:0]   key_r;

  logic               out_hit_r, out_evicted_r;
  logic [KEY_W-1:0]   out_evicted_key_r;

  // compare stage
  logic [ENTRIES-1:0] hit_vec, evict_vec, free_vec;
  logic [CMP_W-1:0]   max_ext, cap;
  logic               full;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]   = valid_r[i] && (key_store_r[i] == in_key);
      evict_vec[i] = valid_r[i] && (CNT_W'(rank_r[i]) == (count_r - CNT_W'(1)));
    end
  end

  // lowest free slot
  assign free_vec = ~valid_r & (valid_r + ENTRIES'(1));

  assign max_ext = CMP_W'(max_entries);
  always_comb begin
    if (max_ext == '0) begin
      cap = CMP_W'(1);
    end else if (max_ext > CMP_W'(ENTRIES)) begin
      cap = CMP_W'(ENTRIES);
    end else begin
      cap = max_ext;
    end
  end
  assign full = (CMP_W'(count_r) >= cap);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit_vec_r    <= hit_vec;
      evict_vec_r  <= evict_vec;
      free_vec_r   <= free_vec;
      need_evict_r <= full;
      req_type_r   <= in_req_type;
      key_r        <= in_key;
    end
  end

  // update stage
  logic               hit_any, do_touch, do_fill, do_evict;
  logic [RANK_W-1:0]  hit_rank;
  logic [KEY_W-1:0]   ev_key;
  logic [ENTRIES-1:0] slot_vec;

  assign hit_any  = |hit_vec_r;
  assign do_touch = hit_any && (req_type_r == lkst_pkg::REQ_LOOKUP);
  assign do_fill  = !hit_any && (req_type_r == lkst_pkg::REQ_INSERT);
  assign do_evict = do_fill && need_evict_r;
  assign slot_vec = need_evict_r ? evict_vec_r : free_vec_r;

  always_comb begin
    hit_rank = '0;
    ev_key   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank = hit_rank | (hit_vec_r[i] ? rank_r[i] : '0);
      ev_key   = ev_key | (evict_vec_r[i] ? key_store_r[i] : '0);
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < ENTRIES; i++) begin
      key_store_nxt[i] = key_store_r[i];
      rank_nxt[i]      = rank_r[i];
      if (do_touch && valid_r[i]) begin
        if (hit_vec_r[i]) begin
          rank_nxt[i] = '0;
        end else if (rank_r[i] < hit_rank) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end else if (do_fill) begin
        if (slot_vec[i]) begin
          key_store_nxt[i] = key_r;
          rank_nxt[i]      = '0;
          valid_nxt[i]     = 1'b1;
        end else if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
      end
    end
    if (do_fill && !need_evict_r) count_nxt = count_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.commit) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      key_store_r       <= key_store_nxt;
      rank_r            <= rank_nxt;
      out_hit_r         <= hit_any;
      out_evicted_r     <= do_evict;
      out_evicted_key_r <= do_evict ? ev_key : '0;
    end
  end

  assign out_hit         = out_hit_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

endmodule

`default_nettype wire

/* design/lru_key_set_tracker.sv */
// LRU key set tracker: a fully associative set of up to max_entries keys in
// recency order. Input channel (in_valid/in_stall) carries req_type and key;
// insert adds a new key as most recent, evicting the least recent when full;
// lookup reports a hit and promotes the key. Each input beat yields exactly
// one result beat (out_hit, out_evicted, out_evicted_key) on the out_ channel.
// Timing: a beat is taken in the idle cycle; all stored keys are compared
// against it in parallel and the results are registered with the request;
// the update state then applies the recency update and loads the result
// register. One item is handled at a time, as set by the compare-then-update
// controller. in_stall is high during the update cycle.
// When out_stall holds the result register full, the update waits and
// in_stall stays high until the result beat goes out.
// Reset (rst_n low, synchronous) empties the set, sets max_entries to 16 and
// needs no clearing pass. The user writes max_entries over the APB-style cfg_
// port at byte address 0 only while the block is idle; this is not enforced.
`default_nettype none

module lru_key_set_tracker #(
  parameter int ENTRIES = lkst_pkg::ENTRIES_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic                                   in_req_type,
  input  wire logic signed [lkst_pkg::KEY_W-1:0]      in_key,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic                                        out_hit,
  output logic                                        out_evicted,
  output logic signed [lkst_pkg::KEY_W-1:0]           out_evicted_key,
  input  wire logic                                   cfg_psel,
  input  wire logic                                   cfg_penable,
  input  wire logic                                   cfg_pwrite,
  input  wire logic [lkst_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  wire logic [lkst_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [lkst_pkg::CFG_DATA_W-1:0]             cfg_prdata,
  output logic                                        cfg_pready
);

  logic [lkst_pkg::MAX_W-1:0] max_entries_r, max_entries_nxt;
  logic                       reg_idx;
  logic                       cfg_wr;
  lkst_pkg::cmd_t             cmd;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[lkst_pkg::CFG_ADDR_W-1];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    max_entries_nxt = max_entries_r;
    if (cfg_wr && (reg_idx == lkst_pkg::REG_MAX_ENTRIES)) begin
      max_entries_nxt = cfg_pwdata[lkst_pkg::MAX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= lkst_pkg::MAX_ENTRIES_RESET;
    end else begin
      max_entries_r <= max_entries_nxt;
    end
  end

  assign cfg_prdata = (reg_idx == lkst_pkg::REG_MAX_ENTRIES)
                      ? lkst_pkg::CFG_DATA_W'(max_entries_r) : '0;

  lkst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lkst_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_req_type),
    .in_key          (in_key),
    .max_entries     (max_entries_r),
    .out_hit         (out_hit),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key)
  );

endmodule

`default_nettype wire

/* design/lkst_checker.sv */
`default_nettype none

module lkst_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic                              out_hit,
  input wire logic                              out_evicted,
  input wire logic [lkst_pkg::KEY_W-1:0]        out_evicted_key
);

  // one item at a time: the cycle after an input beat is never open
  a_in_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken in the cycle after a beat");

  // a fresh result only follows an input beat: beat, update, then result shows
  a_result_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a preceding input beat");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> !out_hit)
    else $error("eviction reported on a hit");

  a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted) |-> (out_evicted_key == '0))
    else $error("evicted key nonzero without eviction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_hit) && $stable(out_evicted) && $stable(out_evicted_key)))
    else $error("stalled result beat changed");

endmodule

bind lru_key_set_tracker lkst_checker u_lkst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_hit         (out_hit),
  .out_evicted     (out_evicted),
  .out_evicted_key (out_evicted_key)
);

`default_nettype wire
